// ===== rtl/core/cnl_pkg.sv =====
// Shared types, name table and lookup functions for the name list matcher.
`default_nettype none

package cnl_pkg;

   localparam int TABLE_USED = 6;
   localparam int NAME_LEN   = 10;
   localparam int LEN_W      = 5;

   localparam logic [7:0]       COMMA_BYTE = 8'h2C;
   localparam logic [LEN_W-1:0] LEN_MAX    = 5'd31;

   // names packed first character in the top byte
   localparam logic [8*NAME_LEN-1:0] NAME_TEXT [TABLE_USED] = '{
      "aes256-cbc", "aes192-cbc", "aes128-cbc",
      "aes256-ctr", "aes192-ctr", "aes128-ctr"
   };

   typedef struct packed {
      logic [7:0] list_byte;
      logic       last_byte;
   } cnl_req_type;

   typedef struct packed {
      logic       found;
      logic [2:0] alg_index;
      logic [5:0] key_bytes;
      logic       mode_ctr;
   } cnl_rsp_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic step;      // item taken while the search is still open
      logic list_end;  // item taken with the last byte flag
      logic comma;     // item is a separator
   } cnl_ctl_type;

   function automatic logic [7:0] name_char(input logic [3:0] idx, input logic [3:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      if (idx < 4'(TABLE_USED) && pos < 4'(NAME_LEN)) begin
         ch = NAME_TEXT[idx[2:0]][8*(NAME_LEN-1-int'(pos)) +: 8];
      end
      return ch;
   endfunction

   function automatic logic [5:0] name_key(input logic [2:0] idx);
      logic [5:0] key;
      unique case (idx)
         3'd0, 3'd3: key = 6'd32;
         3'd1, 3'd4: key = 6'd24;
         3'd2, 3'd5: key = 6'd16;
         default:    key = 6'd0;
      endcase
      return key;
   endfunction

   function automatic logic name_ctr(input logic [2:0] idx);
      logic ctr;
      unique case (idx)
         3'd3, 3'd4, 3'd5: ctr = 1'b1;
         default:          ctr = 1'b0;
      endcase
      return ctr;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cnl_match_cell.sv =====
// One table slot: keeps the slot's alive bit and joins the first-hit priority chain.
`default_nettype none

module cnl_match_cell
   import cnl_pkg::*;
#(
   parameter int INDEX        = 0,
   parameter int MAX_NAME_LEN = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cnl_ctl_type      ctl,
   input  wire logic [7:0]       list_byte,
   input  wire logic [LEN_W-1:0] token_len,   // length before this byte
   input  wire logic [LEN_W-1:0] eval_len,    // length of the token if it ends now
   input  wire logic             hit_in,      // a lower slot already matches
   output logic                  hit_out,
   output logic                  first_hit
);

   localparam logic       USABLE = (INDEX < TABLE_USED) && (NAME_LEN <= MAX_NAME_LEN);
   localparam logic [3:0] IDX    = 4'(INDEX);

   logic alive_ff;
   logic alive_in;
   logic char_ok;
   logic alive_take;
   logic eval_alive;
   logic match;

   always_comb begin
      char_ok    = USABLE && (token_len < LEN_W'(NAME_LEN)) &&
                   (name_char(IDX, token_len[3:0]) == list_byte);
      alive_take = alive_ff && char_ok;
      eval_alive = ctl.comma ? alive_ff : alive_take;
      match      = eval_alive && USABLE && (eval_len == LEN_W'(NAME_LEN));
      first_hit  = match && !hit_in;
      hit_out    = match || hit_in;
   end

   // after a comma or the list's last byte the bit restarts; if the search closed at the comma it is unused
   always_comb begin
      alive_in = alive_ff;
      priority if (ctl.list_end) begin
         alive_in = 1'b1;
      end else if (ctl.step) begin
         alive_in = ctl.comma ? 1'b1 : alive_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b1;
      end else begin
         alive_ff <= alive_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cipher_name_list_match_top.sv =====
// Top level: token tracking, row of match cells, result register.
// The result is registered: rsp_valid rises in the cycle after the list's last byte is taken.
// Throughput: one byte per cycle while req_stall is low; each byte is compared against
// every slot in the cell row at once; the cell priority chain picks the lowest matching slot.
// Reset (synchronous, active high) clears the token, the search and the result valid flag.
// After each last byte the token and search state return to their reset values on their own.
`default_nettype none

module cipher_name_list_match_top
   import cnl_pkg::*;
#(
   parameter int NUM_NAMES    = 6,
   parameter int MAX_NAME_LEN = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire cnl_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output cnl_rsp_type      rsp_data
);

   logic [LEN_W-1:0] token_len_ff, token_len_in;
   logic             search_over_ff, search_over_in;
   logic             chosen_valid_ff, chosen_valid_in;
   logic [2:0]       chosen_index_ff, chosen_index_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cnl_rsp_type      rsp_data_ff, rsp_data_in;

   logic             accept;
   cnl_ctl_type      ctl;
   logic [LEN_W-1:0] len_inc;
   logic [LEN_W-1:0] eval_len;
   logic [NUM_NAMES:0]   hit_chain;
   logic [NUM_NAMES-1:0] first_hit;
   logic [2:0]       sel_index;
   logic             end_now;
   logic             take_match;
   logic             final_found;
   logic [2:0]       final_index;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctl.step     = accept && !search_over_ff;
      ctl.list_end = accept && req_data.last_byte;
      ctl.comma    = (req_data.list_byte == COMMA_BYTE);
      len_inc      = (token_len_ff == LEN_MAX) ? LEN_MAX : token_len_ff + LEN_W'(1);
      eval_len     = ctl.comma ? token_len_ff : len_inc;
   end

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < NUM_NAMES; i++) begin : g_cell
      cnl_match_cell #(
         .INDEX        (i),
         .MAX_NAME_LEN (MAX_NAME_LEN)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .list_byte (req_data.list_byte),
         .token_len (token_len_ff),
         .eval_len  (eval_len),
         .hit_in    (hit_chain[i]),
         .hit_out   (hit_chain[i+1]),
         .first_hit (first_hit[i])
      );
   end

   always_comb begin
      sel_index = 3'd0;
      for (int i = 0; i < NUM_NAMES; i++) begin
         if (first_hit[i]) begin
            sel_index = sel_index | 3'(i);
         end
      end
      end_now     = ctl.step && (ctl.comma || req_data.last_byte);
      take_match  = end_now && (eval_len != '0) && hit_chain[NUM_NAMES];
      final_found = chosen_valid_ff || take_match;
      final_index = chosen_valid_ff ? chosen_index_ff : (take_match ? sel_index : 3'd0);
   end

   always_comb begin
      token_len_in    = token_len_ff;
      search_over_in  = search_over_ff;
      chosen_valid_in = chosen_valid_ff;
      chosen_index_in = chosen_index_ff;
      priority if (ctl.list_end) begin
         token_len_in    = '0;
         search_over_in  = 1'b0;
         chosen_valid_in = 1'b0;
         chosen_index_in = 3'd0;
      end else if (ctl.step) begin
         token_len_in = ctl.comma ? '0 : len_inc;
         if (end_now && (eval_len == '0 || take_match)) begin
            search_over_in = 1'b1;
         end
         if (take_match) begin
            chosen_valid_in = 1'b1;
            chosen_index_in = sel_index;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (ctl.list_end) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.found     = final_found;
         rsp_data_in.alg_index = final_found ? final_index : 3'd0;
         rsp_data_in.key_bytes = final_found ? name_key(final_index) : 6'd0;
         rsp_data_in.mode_ctr  = final_found ? name_ctr(final_index) : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_len_ff    <= '0;
         search_over_ff  <= 1'b0;
         chosen_valid_ff <= 1'b0;
         chosen_index_ff <= 3'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         token_len_ff    <= token_len_in;
         search_over_ff  <= search_over_in;
         chosen_valid_ff <= chosen_valid_in;
         chosen_index_ff <= chosen_index_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_first_hit_unique: assert property (@(posedge clock) $onehot0(first_hit))
      else $error("more than one slot picked as first hit");

   a_list_end_clears: assert property (@(posedge clock) disable iff (reset)
      ctl.list_end |=> (token_len_ff == '0 && !search_over_ff && !chosen_valid_ff))
      else $error("matcher state not cleared after last byte");

   a_chosen_closes: assert property (@(posedge clock) disable iff (reset)
      chosen_valid_ff |-> search_over_ff)
      else $error("chosen name while search still open");

   a_found_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |->
         (rsp_data.key_bytes == 6'd16 || rsp_data.key_bytes == 6'd24 ||
          rsp_data.key_bytes == 6'd32))
      else $error("found result with bad key length");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         (rsp_data.alg_index == 3'd0 && rsp_data.key_bytes == 6'd0 && !rsp_data.mode_ctr))
      else $error("empty result carries nonzero fields");

endmodule

`default_nettype wire
